>>> hdl/hbfn_pkg.sv
// Shared codes, status structs and the bit encoder for the hierarchical bitmap search.
package hbfn_pkg;

  localparam int unsigned POS_W  = 12;
  localparam int unsigned ENC_W  = 64;
  localparam int unsigned ENC_IW = 6;

  localparam logic ACT_CHANGE = 1'b0;
  localparam logic ACT_FIND   = 1'b1;

  // write-back of one word's summary bits
  typedef struct packed {
    logic we;
    logic has_set;
    logic has_clear;
  } sum_upd_t;

  typedef struct packed {
    logic word_live;   // word has been written with a one at some point and still holds one
    logic next_found;  // a later word is marked for the value sought
    logic any_set;
    logic any_clear;
  } sum_stat_t;

  // index of the lowest set bit, 0 when none
  function automatic logic [ENC_IW-1:0] lowest_bit(input logic [ENC_W-1:0] v);
    logic [ENC_IW-1:0] idx;
    idx = '0;
    for (int i = ENC_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = ENC_IW'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hdl/hbfn_word_ram.sv
// Bitmap word store: one write port, one read port with registered read data.
module hbfn_word_ram #(
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 64
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/hbfn_summary.sv
// Per-word summary masks, next marked word search and whole-map flags.
module hbfn_summary #(
  parameter int unsigned IDX_W = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hbfn_pkg::sum_upd_t   upd_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic                 val_i,
  output hbfn_pkg::sum_stat_t  stat_o,
  output logic [IDX_W-1:0]     next_idx_o
);
  import hbfn_pkg::*;

  localparam int unsigned NUM_WORDS = 2**IDX_W;

  logic [NUM_WORDS-1:0] has_set_q;
  logic [NUM_WORDS-1:0] has_clear_q;
  logic [NUM_WORDS-1:0] cand;
  logic [IDX_W-1:0]     next_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_set_q   <= '0;
      has_clear_q <= '1;
    end else if (upd_i.we) begin
      has_set_q[idx_i]   <= upd_i.has_set;
      has_clear_q[idx_i] <= upd_i.has_clear;
    end
  end

  // words strictly above the current one that hold the value sought
  always_comb begin
    next_idx = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      cand[i] = (val_i ? has_set_q[i] : has_clear_q[i]) && (IDX_W'(i) > idx_i);
    end
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        next_idx = IDX_W'(i);
      end
    end
  end

  assign stat_o.word_live  = has_set_q[idx_i];
  assign stat_o.next_found = |cand;
  assign stat_o.any_set    = |has_set_q;
  assign stat_o.any_clear  = |has_clear_q;
  assign next_idx_o        = next_idx;

endmodule

>>> hdl/hierarchical_bitmap_find_next_unit.sv
// Top level of the hierarchical bitmap: sequencer, word store and summary masks.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries action_i, position_i and
//   bit_value_i. A change sets or clears one bit; a find returns the first bit
//   at or after position_i equal to bit_value_i.
//   Output channel (out_valid_o / out_stall_i) carries one result per item:
//   found_o, found_position_o, any_set_o and any_clear_o, the flags taken
//   after the item has taken effect.
// Sequence:
//   One item at a time, each step waiting on the store's registered read. A
//   change, or a find that ends in its start word, passes LOOK, CHECK and FIN;
//   a find that moves to a later word adds LOOK2 and CHECK2; a position beyond
//   the map goes straight to FIN. A new item is taken only in IDLE.
// Reset:
//   The map reads all zeros straight after reset; a word whose summary says it
//   holds no one is read as zero, so the store needs no clearing pass.
// Stall:
//   A finished result sits in the output register until transferred; the
//   next item is accepted meanwhile and holds in its last step if the
//   register is still full.
module hierarchical_bitmap_find_next_unit #(
  parameter int unsigned MAP_BITS_LOG2  = 12,
  parameter int unsigned WORD_BITS_LOG2 = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [hbfn_pkg::POS_W-1:0] position_i,
  input  logic                     bit_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic [hbfn_pkg::POS_W-1:0] found_position_o,
  output logic                     any_set_o,
  output logic                     any_clear_o
);
  import hbfn_pkg::*;

  localparam int unsigned WB    = 2**WORD_BITS_LOG2;
  localparam int unsigned IDX_W = MAP_BITS_LOG2 - WORD_BITS_LOG2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_LOOK2,
    ST_CHECK2,
    ST_FIN
  } state_e;

  state_e                    state_q, state_d;
  logic                      act_q, act_d;
  logic                      val_q, val_d;
  logic [WORD_BITS_LOG2-1:0] off_q, off_d;
  logic [IDX_W-1:0]          cur_word_q, cur_word_d;
  logic                      res_found_q, res_found_d;
  logic [POS_W-1:0]          res_pos_q, res_pos_d;
  logic                      out_valid_q, out_valid_d;
  logic                      found_q, found_d;
  logic [POS_W-1:0]          found_pos_q, found_pos_d;
  logic                      any_set_q, any_set_d;
  logic                      any_clear_q, any_clear_d;

  logic [WB-1:0]             rd_data;
  logic [WB-1:0]             word_cur;
  logic [WB-1:0]             look;
  logic [WB-1:0]             new_word;
  logic                      ram_we;
  logic                      hit;
  logic [ENC_IW-1:0]         enc_full;
  logic [WORD_BITS_LOG2-1:0] bit_idx;
  logic                      out_of_range;
  sum_upd_t                  upd;
  sum_stat_t                 stat;
  logic [IDX_W-1:0]          next_idx;

  hbfn_word_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (WB)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_word_q),
    .wdata_i (new_word),
    .raddr_i (cur_word_q),
    .rdata_o (rd_data)
  );

  hbfn_summary #(
    .IDX_W (IDX_W)
  ) u_summary (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .idx_i      (cur_word_q),
    .val_i      (val_q),
    .stat_o     (stat),
    .next_idx_o (next_idx)
  );

  // a word with no summary set bit is all zeros, written or not
  assign word_cur = stat.word_live ? rd_data : '0;
  assign new_word = val_q ? (word_cur | (WB'(1) << off_q))
                          : (word_cur & ~(WB'(1) << off_q));

  always_comb begin
    look = val_q ? word_cur : ~word_cur;
    if (state_q == ST_CHECK) begin
      look = look & ({WB{1'b1}} << off_q);
    end
  end

  assign hit          = |look;
  assign enc_full     = lowest_bit(ENC_W'(look));
  assign bit_idx      = enc_full[WORD_BITS_LOG2-1:0];
  assign out_of_range = (position_i >> MAP_BITS_LOG2) != '0;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    val_d       = val_q;
    off_d       = off_q;
    cur_word_d  = cur_word_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q & out_stall_i;
    found_d     = found_q;
    found_pos_d = found_pos_q;
    any_set_d   = any_set_q;
    any_clear_d = any_clear_q;
    ram_we      = 1'b0;
    upd         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d       = action_i;
          val_d       = bit_value_i;
          off_d       = position_i[WORD_BITS_LOG2-1:0];
          cur_word_d  = position_i[MAP_BITS_LOG2-1:WORD_BITS_LOG2];
          res_found_d = 1'b0;
          res_pos_d   = '0;
          state_d     = out_of_range ? ST_FIN : ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (act_q == ACT_CHANGE) begin
          ram_we        = 1'b1;
          upd.we        = 1'b1;
          upd.has_set   = |new_word;
          upd.has_clear = ~&new_word;
          state_d       = ST_FIN;
        end else if (hit) begin
          res_found_d = 1'b1;
          res_pos_d   = POS_W'({cur_word_q, bit_idx});
          state_d     = ST_FIN;
        end else if (stat.next_found) begin
          cur_word_d = next_idx;
          state_d    = ST_LOOK2;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_LOOK2: begin
        state_d = ST_CHECK2;
      end
      ST_CHECK2: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_pos_d   = POS_W'({cur_word_q, bit_idx});
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          found_pos_d = res_pos_q;
          any_set_d   = stat.any_set;
          any_clear_d = stat.any_clear;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= ACT_CHANGE;
      val_q       <= 1'b0;
      off_q       <= '0;
      cur_word_q  <= '0;
      res_found_q <= 1'b0;
      res_pos_q   <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      found_pos_q <= '0;
      any_set_q   <= 1'b0;
      any_clear_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      val_q       <= val_d;
      off_q       <= off_d;
      cur_word_q  <= cur_word_d;
      res_found_q <= res_found_d;
      res_pos_q   <= res_pos_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      found_pos_q <= found_pos_d;
      any_set_q   <= any_set_d;
      any_clear_q <= any_clear_d;
    end
  end

  assign in_stall_o       = state_q != ST_IDLE;
  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign found_position_o = found_pos_q;
  assign any_set_o        = any_set_q;
  assign any_clear_o      = any_clear_q;

endmodule

>>> tb/sv/tb_hierarchical_bitmap_find_next_unit.sv
// Testbench for the hierarchical bitmap find-next unit: self-predicting, random gaps and stalls.
`timescale 1ns / 1ps

module tb_hierarchical_bitmap_find_next_unit;

  localparam int unsigned MAP_LOG2     = 12;
  localparam int unsigned WORD_LOG2    = 6;
  localparam int unsigned POS_W        = hbfn_pkg::POS_W;
  localparam int unsigned WORD_BITS    = 1 << WORD_LOG2;
  localparam int unsigned NUM_WORDS    = 1 << (MAP_LOG2 - WORD_LOG2);
  localparam int unsigned MAP_SIZE     = 1 << MAP_LOG2;
  localparam int unsigned RANDOM_ITEMS = 760;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned GAP_PCT      = 21;
  // words 30 to 33 are filled completely
  localparam int          FULL_LO      = 1920;
  localparam int          FULL_HI      = 2175;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] fpos;
    logic             any_set;
    logic             any_clear;
  } bitmap_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             action_i    = hbfn_pkg::ACT_CHANGE;
  logic [POS_W-1:0] position_i  = '0;
  logic             bit_value_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             found_o;
  logic [POS_W-1:0] found_position_o;
  logic             any_set_o;
  logic             any_clear_o;

  // predictor state: the map and its per-word summaries
  logic [WORD_BITS-1:0] map_word [NUM_WORDS];
  logic [NUM_WORDS-1:0] word_set_mask;
  logic [NUM_WORDS-1:0] word_clear_mask;

  bitmap_result_t expected_results [$];
  bitmap_result_t want_res;
  bitmap_result_t got_res;
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  bit             gaps_on     = 1'b1;

  hierarchical_bitmap_find_next_unit #(
    .MAP_BITS_LOG2 (MAP_LOG2),
    .WORD_BITS_LOG2(WORD_LOG2)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .position_i      (position_i),
    .bit_value_i     (bit_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .found_position_o(found_position_o),
    .any_set_o       (any_set_o),
    .any_clear_o     (any_clear_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(0, 99) < GAP_PCT);
  end

  function automatic int unsigned first_one(input logic [WORD_BITS-1:0] v);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) begin
        return i;
      end
    end
    return 0;
  endfunction

  // applies one item to the predictor and returns the result it should give
  function automatic bitmap_result_t predict_bitmap(input logic act, input logic [POS_W-1:0] pos,
                                                    input logic val);
    bitmap_result_t       r;
    int unsigned          w;
    int unsigned          off;
    int unsigned          nw;
    logic [WORD_BITS-1:0] look;
    r = '0;
    if (pos < MAP_SIZE) begin
      w   = pos >> WORD_LOG2;
      off = pos % WORD_BITS;
      if (act == hbfn_pkg::ACT_CHANGE) begin
        map_word[w][off]   = val;
        word_set_mask[w]   = |map_word[w];
        word_clear_mask[w] = ~&map_word[w];
      end else begin
        look = val ? map_word[w] : ~map_word[w];
        look = look & ({WORD_BITS{1'b1}} << off);
        if (look != '0) begin
          r.found = 1'b1;
          r.fpos  = POS_W'(w * WORD_BITS + first_one(look));
        end else begin
          // start word exhausted: take the next word the summary marks
          nw = NUM_WORDS;
          for (int i = NUM_WORDS - 1; i > int'(w); i--) begin
            if (val ? word_set_mask[i] : word_clear_mask[i]) begin
              nw = i;
            end
          end
          if (nw < NUM_WORDS) begin
            look = val ? map_word[nw] : ~map_word[nw];
            if (look != '0) begin
              r.found = 1'b1;
              r.fpos  = POS_W'(nw * WORD_BITS + first_one(look));
            end
          end
        end
      end
    end
    r.any_set   = |word_set_mask;
    r.any_clear = |word_clear_mask;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_res = '{found_o, found_position_o, any_set_o, any_clear_o};
      if (expected_results.size() == 0) begin
        $display("%0t: result with none outstanding: found %0b pos %0d set %0b clear %0b",
                 $time, found_o, found_position_o, any_set_o, any_clear_o);
        error_count++;
      end else begin
        want_res = expected_results.pop_front();
        if (got_res.found !== want_res.found) begin
          $display("%0t: found expected %0b, got %0b", $time, want_res.found, got_res.found);
          error_count++;
        end
        if (got_res.fpos !== want_res.fpos) begin
          $display("%0t: found_position expected %0d, got %0d", $time, want_res.fpos,
                   got_res.fpos);
          error_count++;
        end
        if (got_res.any_set !== want_res.any_set) begin
          $display("%0t: any_set expected %0b, got %0b", $time, want_res.any_set,
                   got_res.any_set);
          error_count++;
        end
        if (got_res.any_clear !== want_res.any_clear) begin
          $display("%0t: any_clear expected %0b, got %0b", $time, want_res.any_clear,
                   got_res.any_clear);
          error_count++;
        end
      end
    end
  end

  // entered just after a rising edge; returns just after the edge of the transfer
  task automatic send_item(input logic act, input logic [POS_W-1:0] pos, input logic val);
    while (gaps_on && ($urandom_range(0, 99) < GAP_PCT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    position_i  <= pos;
    bit_value_i <= val;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    expected_results.push_back(predict_bitmap(act, pos, val));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_results.size() != 0);
  endtask

  task automatic test_edges();
    send_item(hbfn_pkg::ACT_FIND, 12'd0, 1'b1);      // empty map, nothing set
    send_item(hbfn_pkg::ACT_FIND, 12'd0, 1'b0);
    send_item(hbfn_pkg::ACT_FIND, 12'd4095, 1'b0);
    send_item(hbfn_pkg::ACT_FIND, 12'd4095, 1'b1);
    send_item(hbfn_pkg::ACT_CHANGE, 12'd4095, 1'b1);
    send_item(hbfn_pkg::ACT_FIND, 12'd0, 1'b1);      // skips to the last word
    send_item(hbfn_pkg::ACT_CHANGE, 12'd0, 1'b1);
    send_item(hbfn_pkg::ACT_FIND, 12'd0, 1'b1);
    send_item(hbfn_pkg::ACT_FIND, 12'd1, 1'b1);
    send_item(hbfn_pkg::ACT_FIND, 12'd4095, 1'b1);
    send_item(hbfn_pkg::ACT_CHANGE, 12'd63, 1'b1);
    send_item(hbfn_pkg::ACT_FIND, 12'd1, 1'b1);
    send_item(hbfn_pkg::ACT_CHANGE, 12'd64, 1'b1);
    send_item(hbfn_pkg::ACT_FIND, 12'd64, 1'b1);
    send_item(hbfn_pkg::ACT_FIND, 12'd63, 1'b0);     // clear search crossing a word edge
    send_item(hbfn_pkg::ACT_CHANGE, 12'd0, 1'b0);
    send_item(hbfn_pkg::ACT_CHANGE, 12'd0, 1'b0);
    send_item(hbfn_pkg::ACT_FIND, 12'd0, 1'b1);
    send_item(hbfn_pkg::ACT_CHANGE, 12'd63, 1'b0);
    send_item(hbfn_pkg::ACT_CHANGE, 12'd64, 1'b0);
    send_item(hbfn_pkg::ACT_CHANGE, 12'd4095, 1'b0);
    send_item(hbfn_pkg::ACT_FIND, 12'd0, 1'b1);      // words set once, now empty again
    send_item(hbfn_pkg::ACT_FIND, 12'd2048, 1'b1);
    wait_drained();
  endtask

  // fills a run of words so clear searches must skip them, then punches holes
  task automatic test_full_map();
    gaps_on = 1'b0;
    for (int p = FULL_LO; p <= FULL_HI; p++) begin
      send_item(hbfn_pkg::ACT_CHANGE, POS_W'(p), 1'b1);
      if (p % WORD_BITS == WORD_BITS - 1) begin
        send_item(hbfn_pkg::ACT_FIND, POS_W'($urandom_range(0, MAP_SIZE - 1)), 1'b0);
      end
    end
    send_item(hbfn_pkg::ACT_FIND, POS_W'(FULL_LO), 1'b0);
    send_item(hbfn_pkg::ACT_FIND, POS_W'(FULL_LO), 1'b1);
    send_item(hbfn_pkg::ACT_CHANGE, 12'd2000, 1'b0);
    send_item(hbfn_pkg::ACT_FIND, POS_W'(FULL_LO), 1'b0);
    send_item(hbfn_pkg::ACT_FIND, 12'd2001, 1'b0);
    send_item(hbfn_pkg::ACT_CHANGE, 12'd2000, 1'b1);
    send_item(hbfn_pkg::ACT_CHANGE, POS_W'(FULL_HI), 1'b0);
    send_item(hbfn_pkg::ACT_FIND, POS_W'(FULL_LO), 1'b0);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int unsigned      n;
    int unsigned      hot;
    int unsigned      set_pct;
    int unsigned      start;
    int unsigned      next_pause;
    logic             v;
    logic [POS_W-1:0] pos;
    n          = 0;
    next_pause = 150;
    hot        = $urandom_range(0, NUM_WORDS - 1);
    while (n < RANDOM_ITEMS) begin
      // alternate phases that drain and refill the map
      set_pct = ((n / 200) % 2 == 0) ? 25 : 80;
      if ($urandom_range(0, 15) == 0) begin
        hot = $urandom_range(0, NUM_WORDS - 1);
      end
      if ($urandom_range(0, 79) == 0) begin
        // whole-word sweep: leaves the word full or empty
        v     = 1'($urandom_range(0, 1));
        start = $urandom_range(0, WORD_BITS - 1);
        for (int k = 0; k < WORD_BITS; k++) begin
          send_item(hbfn_pkg::ACT_CHANGE, POS_W'(hot * WORD_BITS + (start + k) % WORD_BITS), v);
        end
        n += WORD_BITS;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            if ($urandom_range(0, 1)) begin
              pos = POS_W'($urandom_range(0, MAP_SIZE - 1));
            end else begin
              pos = POS_W'(hot * WORD_BITS + $urandom_range(0, WORD_BITS - 1));
            end
            send_item(hbfn_pkg::ACT_FIND, pos, 1'($urandom_range(0, 1)));
          end
          4, 5, 6: begin
            pos = POS_W'(hot * WORD_BITS + $urandom_range(0, WORD_BITS - 1));
            send_item(hbfn_pkg::ACT_CHANGE, pos, $urandom_range(0, 99) < set_pct);
          end
          7: begin
            send_item(hbfn_pkg::ACT_CHANGE, POS_W'($urandom_range(0, MAP_SIZE - 1)),
                      1'($urandom_range(0, 1)));
          end
          default: begin
            // start at a word edge
            pos = POS_W'($urandom_range(0, NUM_WORDS - 1) * WORD_BITS +
                         ($urandom_range(0, 1) ? WORD_BITS - 1 : 0));
            send_item(hbfn_pkg::ACT_FIND, pos, 1'($urandom_range(0, 1)));
          end
        endcase
        n++;
      end
      if (n >= next_pause) begin
        wait_drained();
        next_pause += 150;
      end
    end
  endtask

  initial begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      map_word[w] = '0;
    end
    word_set_mask   = '0;
    word_clear_mask = '1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_edges();
    test_full_map();
    test_random();
    wait_drained();
    repeat (12) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/hbfn_pkg.sv
hdl/hbfn_word_ram.sv
hdl/hbfn_summary.sv
hdl/hierarchical_bitmap_find_next_unit.sv
tb/sv/tb_hierarchical_bitmap_find_next_unit.sv
